@@ hdl/looped_linear_interp_resampler_top_defines.svh @@
// Assertion macros for the looped linear-interpolation resampler.
// Used by the port checker; needs i_clk and i_rst_n in scope.
`ifndef LOOPED_LINEAR_INTERP_RESAMPLER_TOP_DEFINES_SVH
`define LOOPED_LINEAR_INTERP_RESAMPLER_TOP_DEFINES_SVH

// checked on every edge, reset included
`define LLIR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

// checked only out of reset
`define LLIR_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

@@ hdl/llir_pkg.sv @@
// Shared constants, codes and the queued item type of the resampler.
// No dependencies.
`default_nettype none

package llir_pkg;

    localparam int MAX_FRAMES = 4096;
    localparam int ADDR_W     = $clog2(MAX_FRAMES);
    localparam int FADDR_W    = 12;
    localparam int SAMPLE_W   = 16;
    localparam int LEN_W      = 13;
    localparam int LOOP_W     = 14;
    localparam int POS_W      = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

    typedef logic [1:0] t_op;
    localparam t_op OP_LOAD    = 2'd0;
    localparam t_op OP_RESTART = 2'd1;
    localparam t_op OP_FRAME   = 2'd2;
    localparam t_op OP_UNUSED  = 2'd3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SOURCE_LENGTH = 2'd0;
    localparam t_cfg_idx CFG_LOOP_COUNT    = 2'd1;

    typedef struct packed {
        t_op                        op;
        logic [FADDR_W-1:0]         frame_address;
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
        logic                       slowed;
    } t_item;

endpackage

`default_nettype wire

@@ hdl/llir_front.sv @@
// Input side: takes items, drops those with no effect, pushes the rest.
// Depends on llir_pkg.
`default_nettype none

module llir_front (
    input  wire                            i_valid,
    input  wire  [1:0]                     i_operation,
    input  wire  [llir_pkg::FADDR_W-1:0]   i_frame_address,
    input  wire  signed [llir_pkg::SAMPLE_W-1:0] i_left_in,
    input  wire  signed [llir_pkg::SAMPLE_W-1:0] i_right_in,
    input  wire                            i_slowed,
    input  wire                            i_full,
    output logic                           o_stall,
    output logic                           o_push,
    output llir_pkg::t_item                o_item
);
    import llir_pkg::*;

    logic keep;

    always_comb begin
        unique case (i_operation)
            OP_LOAD:    keep = 32'(i_frame_address) < 32'(MAX_FRAMES);
            OP_RESTART: keep = 1'b1;
            OP_FRAME:   keep = 1'b1;
            default:    keep = 1'b0;
        endcase
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full && keep;

    assign o_item.op            = i_operation;
    assign o_item.frame_address = i_frame_address;
    assign o_item.left_in       = i_left_in;
    assign o_item.right_in      = i_right_in;
    assign o_item.slowed        = i_slowed;

endmodule

`default_nettype wire

@@ hdl/llir_fifo.sv @@
// Short item queue between front and back ends.
// Depends on llir_pkg.
`default_nettype none

module llir_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  llir_pkg::t_item  i_item,
    input  wire              i_pop,
    output llir_pkg::t_item  o_item,
    output logic             o_valid,
    output logic             o_full
);
    import llir_pkg::*;

    t_item                r_buf [FIFO_DEPTH];
    logic [FIFO_PTR_W:0]  r_wr, n_wr;
    logic [FIFO_PTR_W:0]  r_rd, n_rd;

    assign o_valid = r_wr != r_rd;
    assign o_full  = (r_wr[FIFO_PTR_W] != r_rd[FIFO_PTR_W]) &&
                     (r_wr[FIFO_PTR_W-1:0] == r_rd[FIFO_PTR_W-1:0]);
    assign o_item  = r_buf[r_rd[FIFO_PTR_W-1:0]];

    assign n_wr = r_wr + (FIFO_PTR_W+1)'(i_push);
    assign n_rd = r_rd + (FIFO_PTR_W+1)'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr[FIFO_PTR_W-1:0]] <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ hdl/llir_back.sv @@
// Execution side: sample memory, play position, loop count, interpolation
// and the output register. Holds the configuration registers. Uses llir_pkg.
`default_nettype none

module llir_back (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  llir_pkg::t_item               i_item,
    input  wire                           i_item_valid,
    output logic                          o_pop,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  llir_pkg::t_cfg_idx            i_cfg_index,
    input  wire  [llir_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                          o_valid,
    input  wire                           i_stall,
    output logic signed [llir_pkg::SAMPLE_W-1:0] o_left_out,
    output logic signed [llir_pkg::SAMPLE_W-1:0] o_right_out,
    output logic                          o_done_res
);
    import llir_pkg::*;

    localparam int SPAN_W = LEN_W + 2;
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_MIX  = 1'b1;

    // (4*lo + (hi-lo)*frac)/4, truncated toward zero
    function automatic logic [SAMPLE_W-1:0] lerp(input logic signed [SAMPLE_W-1:0] lo,
                                                 input logic signed [SAMPLE_W-1:0] hi,
                                                 input logic [1:0] frac);
        logic signed [SAMPLE_W:0]   diff;
        logic signed [SAMPLE_W+3:0] prod;
        logic signed [SAMPLE_W+3:0] num;
        logic signed [SAMPLE_W+3:0] biased;
        logic signed [SAMPLE_W+3:0] quot;
        diff   = (SAMPLE_W+1)'(hi) - (SAMPLE_W+1)'(lo);
        prod   = (SAMPLE_W+4)'(diff) * $signed({{(SAMPLE_W+1){1'b0}}, frac});
        num    = ((SAMPLE_W+4)'(lo) <<< 2) + prod;
        biased = num + (num[SAMPLE_W+3] ? (SAMPLE_W+4)'(3) : (SAMPLE_W+4)'(0));
        quot   = biased >>> 2;
        return quot[SAMPLE_W-1:0];
    endfunction

    logic [2*SAMPLE_W-1:0] r_mem [MAX_FRAMES];
    logic [2*SAMPLE_W-1:0] r_lo_word, r_hi_word;

    logic                r_state, n_state;
    logic [LEN_W-1:0]    r_len;
    logic [LOOP_W-1:0]   r_loop_cnt;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [LOOP_W-1:0]   r_loops, n_loops;
    logic                r_finished, n_finished;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_frac, n_frac;
    logic [SAMPLE_W-1:0] r_left, n_left;
    logic [SAMPLE_W-1:0] r_right, n_right;
    logic                r_done, n_done;

    logic [LEN_W-1:0]    len_eff;
    logic [SPAN_W-1:0]   span;
    logic [POS_W-1:0]    pos_eff;
    logic [LEN_W-1:0]    hi_raw;
    logic [ADDR_W-1:0]   lo_idx, hi_idx;
    logic [SPAN_W-1:0]   adv;
    logic                wrap;
    logic                out_free;
    logic                mem_we;

    always_comb begin
        priority if (r_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(r_len) > 32'(MAX_FRAMES)) begin
            len_eff = LEN_W'(MAX_FRAMES);
        end else begin
            len_eff = r_len;
        end
    end

    assign span    = {len_eff, 2'b00};
    // position past a lowered length restarts from the top, no pass used
    assign pos_eff = (SPAN_W'(r_pos) >= span) ? '0 : r_pos;
    assign lo_idx  = ADDR_W'(pos_eff[POS_W-1:2]);
    assign hi_raw  = LEN_W'(pos_eff[POS_W-1:2]) + LEN_W'(pos_eff[1:0] != 2'b00);
    assign hi_idx  = (hi_raw == len_eff) ? '0 : ADDR_W'(hi_raw);
    assign adv     = SPAN_W'(pos_eff) + (i_item.slowed ? SPAN_W'(1) : SPAN_W'(4));
    assign wrap    = adv >= span;

    assign out_free    = !r_out_valid || !i_stall;
    assign o_pop       = (r_state == ST_IDLE) && i_item_valid &&
                         ((i_item.op != OP_FRAME) || out_free);
    assign mem_we      = o_pop && (i_item.op == OP_LOAD);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_loops     = r_loops;
        n_finished  = r_finished;
        n_out_valid = r_out_valid && i_stall;
        n_frac      = r_frac;
        n_left      = r_left;
        n_right     = r_right;
        n_done      = r_done;
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    unique case (i_item.op)
                        OP_RESTART: begin
                            n_pos      = '0;
                            n_loops    = r_loop_cnt;
                            n_finished = 1'b0;
                        end
                        OP_FRAME: begin
                            if (r_finished) begin
                                n_out_valid = 1'b1;
                                n_left      = '0;
                                n_right     = '0;
                                n_done      = 1'b1;
                            end else begin
                                n_state = ST_MIX;
                                n_frac  = pos_eff[1:0];
                                n_pos   = wrap ? POS_W'(adv - span) : POS_W'(adv);
                                if (wrap) begin
                                    if (r_loops == '0) begin
                                        n_finished = 1'b1;
                                    end else begin
                                        n_loops = r_loops - LOOP_W'(1);
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MIX: begin
                // memory words are in; output register is known empty here
                n_out_valid = 1'b1;
                n_left  = lerp(r_lo_word[SAMPLE_W-1:0], r_hi_word[SAMPLE_W-1:0], r_frac);
                n_right = lerp(r_lo_word[2*SAMPLE_W-1:SAMPLE_W],
                               r_hi_word[2*SAMPLE_W-1:SAMPLE_W], r_frac);
                n_done  = 1'b0;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_loops     <= '0;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
            r_len       <= LEN_RESET;
            r_loop_cnt  <= '0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_loops     <= n_loops;
            r_finished  <= n_finished;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SOURCE_LENGTH: r_len      <= i_cfg_data[LEN_W-1:0];
                    CFG_LOOP_COUNT:    r_loop_cnt <= i_cfg_data[LOOP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_frac  <= n_frac;
        r_left  <= n_left;
        r_right <= n_right;
        r_done  <= n_done;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[ADDR_W'(i_item.frame_address)] <= {i_item.right_in, i_item.left_in};
        end
        r_lo_word <= r_mem[lo_idx];
        r_hi_word <= r_mem[hi_idx];
    end

    assign o_valid     = r_out_valid;
    assign o_left_out  = r_left;
    assign o_right_out = r_right;
    assign o_done_res  = r_done;

endmodule

`default_nettype wire

@@ hdl/looped_linear_interp_resampler_top.sv @@
// Top level of the looped linear-interpolation resampler.
// Instantiates llir_front, llir_fifo and llir_back; uses llir_pkg.
//
//  channel  direction  handshake                 payload
//  input    in         i_valid / o_stall         operation, address, samples, slowed
//  output   out        o_valid / i_stall         left_out, right_out, done_res
//  config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Load and restart act as they are popped; unused codes are dropped at the
// input. A frame has a registered memory read, then interpolation, with no
// new item popped in between, or is silent once playback has finished.
// A four-entry queue keeps taking input while the output stalls, until full.
// Reset clears position, loop count, finished flag and the queue; the
// sample memory is not cleared and holds nothing until loaded.
`default_nettype none

module looped_linear_interp_resampler_top (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_stall,
    input  wire  [1:0]                     i_operation,
    input  wire  [llir_pkg::FADDR_W-1:0]   i_frame_address,
    input  wire  signed [llir_pkg::SAMPLE_W-1:0] i_left_in,
    input  wire  signed [llir_pkg::SAMPLE_W-1:0] i_right_in,
    input  wire                            i_slowed,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [llir_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [llir_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_valid,
    input  wire                            i_stall,
    output logic signed [llir_pkg::SAMPLE_W-1:0] o_left_out,
    output logic signed [llir_pkg::SAMPLE_W-1:0] o_right_out,
    output logic                           o_done_res
);
    import llir_pkg::*;

    t_item push_item;
    t_item head_item;
    logic  push;
    logic  pop;
    logic  head_valid;
    logic  full;

    llir_front u_front (
        .i_valid         (i_valid),
        .i_operation     (i_operation),
        .i_frame_address (i_frame_address),
        .i_left_in       (i_left_in),
        .i_right_in      (i_right_in),
        .i_slowed        (i_slowed),
        .i_full          (full),
        .o_stall         (o_stall),
        .o_push          (push),
        .o_item          (push_item)
    );

    llir_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_valid (head_valid),
        .o_full  (full)
    );

    llir_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (head_item),
        .i_item_valid (head_valid),
        .o_pop        (pop),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (t_cfg_idx'(i_cfg_index)),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_left_out   (o_left_out),
        .o_right_out  (o_right_out),
        .o_done_res   (o_done_res)
    );

endmodule

`default_nettype wire

@@ hdl/llir_checker.sv @@
// Port-level checks for the resampler top, attached by bind.
// Depends on looped_linear_interp_resampler_top_defines.svh.
`default_nettype none

`include "looped_linear_interp_resampler_top_defines.svh"

module llir_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_stall,
    input wire        o_valid,
    input wire        i_stall,
    input wire [15:0] o_left_out,
    input wire [15:0] o_right_out,
    input wire        o_done_res
);

    // a held result keeps its payload
    `LLIR_ASSERT_RST(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_left_out) && $stable(o_right_out) && $stable(o_done_res), "output changed while stalled")

    // finished playback is silent
    `LLIR_ASSERT_RST(a_done_silent, o_valid && o_done_res |-> o_left_out == 16'd0 && o_right_out == 16'd0, "done frame not silent")

    // reset empties the output register
    `LLIR_ASSERT(a_rst_out, !i_rst_n |=> !o_valid, "output valid after reset")

    // reset empties the queue, so input is taken straight away
    `LLIR_ASSERT(a_rst_stall, !i_rst_n |=> !o_stall, "input stalled after reset")

endmodule

bind looped_linear_interp_resampler_top llir_checker u_llir_checker (.*);

`default_nettype wire
